// ===== rtl/ssc_pkg.sv =====
// Package for the subarray sum counter: sizes, the sequencer state type and
// small arithmetic helpers. No dependencies.
`default_nettype none

package ssc_pkg;

  localparam int MaxElementsDefault = 256;
  localparam int ElemWidth = 16;
  localparam int SumWidth = 25;
  localparam int CountWidth = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ssc_state_t;

  function automatic logic [SumWidth-1:0] sext_elem(input logic [ElemWidth-1:0] e);
    sext_elem = {{(SumWidth - ElemWidth){e[ElemWidth-1]}}, e};
  endfunction

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] c);
    sat_inc = (c == {CountWidth{1'b1}}) ? c : c + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ssc_in_if.sv =====
// Element request channel: valid/ready handshake with one array element.
// Uses the widths from ssc_pkg.
`default_nettype none

interface ssc_in_if;
  import ssc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [ElemWidth-1:0] element_value;
  logic                        last_element;

  modport source (output valid, output element_value, output last_element, input ready);
  modport sink (input valid, input element_value, input last_element, output ready);
endinterface

`default_nettype wire

// ===== rtl/ssc_out_if.sv =====
// Result request channel: valid/ready handshake with the running match count.
// Uses the widths from ssc_pkg.
`default_nettype none

interface ssc_out_if;
  import ssc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CountWidth-1:0] match_count;
  logic                  array_done;
  logic                  overflowed;

  modport source (output valid, output match_count, output array_done, output overflowed,
                  input ready);
  modport sink (input valid, input match_count, input array_done, input overflowed,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/subarray_sum_equals_target_counter.sv =====
// Counts contiguous subarrays whose sum equals a programmed target, using a
// prefix sum store scanned one entry per cycle. Depends on ssc_pkg and the
// ssc_in_if / ssc_out_if channel interfaces.
//
//   channel   dir   payload                                   handshake
//   in_ch     in    element_value, last_element               valid/ready
//   out_ch    out   match_count, array_done, overflowed       valid/ready
//   cfg       in    cfg_data (target_sum)                     cfg_we, no wait
//
// An element sweeps the N prefixes stored for the current array (at most
// MAX_ELEMENTS) through the single read port of the prefix store, one entry
// per cycle, and the last read is compared in the cycle after it. With an
// empty store nothing is read, and an element after overflow skips the scan.
// Reset clears the control state apart from last_q; the store needs no
// clearing. A result waits in the output register, and the next element is
// accepted meanwhile; its result is held back until the previous one is taken.
`default_nettype none

module subarray_sum_equals_target_counter
  import ssc_pkg::*;
#(
  parameter int MAX_ELEMENTS = MaxElementsDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic signed [SumWidth-1:0] cfg_data,
  ssc_in_if.sink                          in_ch,
  ssc_out_if.source                       out_ch
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ELEMENTS);

  ssc_state_t state, state_next;

  logic [SumWidth-1:0]   target_sum;
  logic [SumWidth-1:0]   running_prefix;
  logic [SumWidth-1:0]   want;
  logic [CountWidth-1:0] running_count;
  logic [CW-1:0]         stored_entries;
  logic                  overflow_flag;
  logic                  last_q;
  logic [CW-1:0]         idx;
  logic                  rd_vld;
  logic [SumWidth-1:0]   rd_data;
  logic [SumWidth-1:0]   prefix_store [MAX_ELEMENTS];

  logic                  accept;
  logic                  skip;
  logic                  scan_rd;
  logic                  finish;
  logic [SumWidth-1:0]   prefix_new;
  logic [SumWidth-1:0]   want_new;

  assign accept     = in_ch.valid && in_ch.ready;
  assign skip       = overflow_flag || (stored_entries >= MaxCount);
  assign prefix_new = running_prefix + sext_elem(in_ch.element_value);
  assign want_new   = prefix_new - target_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    scan_rd     = 1'b0;
    finish      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_next = skip ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_rd = (idx < stored_entries);
        if (!scan_rd && !rd_vld) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_ch.valid || out_ch.ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (scan_rd) begin
      rd_data <= prefix_store[idx[AW-1:0]];
    end
    if (finish && !overflow_flag) begin
      prefix_store[stored_entries[AW-1:0]] <= running_prefix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum     <= '0;
      running_prefix <= '0;
      running_count  <= '0;
      stored_entries <= '0;
      overflow_flag  <= 1'b0;
      rd_vld         <= 1'b0;
      idx            <= '0;
      out_ch.valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        target_sum <= cfg_data;
      end
      if (accept) begin
        last_q <= in_ch.last_element;
        idx    <= '0;
        rd_vld <= 1'b0;
        if (skip) begin
          overflow_flag <= 1'b1;
        end else begin
          running_prefix <= prefix_new;
          want           <= want_new;
          if (want_new == '0) begin
            running_count <= sat_inc(running_count);
          end
        end
      end
      if (state == ST_SCAN) begin
        rd_vld <= scan_rd;
        if (scan_rd) begin
          idx <= idx + 1'b1;
        end
        if (rd_vld && (rd_data == want)) begin
          running_count <= sat_inc(running_count);
        end
      end
      if (finish) begin
        out_ch.valid       <= 1'b1;
        out_ch.match_count <= running_count;
        out_ch.array_done  <= last_q;
        out_ch.overflowed  <= overflow_flag;
        if (last_q) begin
          running_prefix <= '0;
          running_count  <= '0;
          stored_entries <= '0;
          overflow_flag  <= 1'b0;
        end else if (!overflow_flag) begin
          stored_entries <= stored_entries + 1'b1;
        end
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
